// ===== design/bpa_pkg.sv =====
// Package: types, constants and helpers for the bitmap page allocator.
package bpa_pkg;

    localparam int MAX_PAGES  = 65536;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int WORD_BITS  = 64;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int MAP_WORDS  = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W    = $clog2(MAP_WORDS);
    localparam int PIDX_W     = $clog2(MAX_PAGES);
    localparam int PCNT_W     = PIDX_W + 1;
    localparam int ADDR_W     = 48;
    localparam int CNT_W      = 17;
    localparam int START_W    = 16;
    localparam int CIDX_W     = 2;

    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_FREE    = 2'd1;
    localparam logic [1:0] KIND_RESERVE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMEM   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_TOTAL = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_START = 2'd2;

    localparam logic [ADDR_W-1:0] BASE_RESET  = 48'h800_0000;
    localparam logic [CNT_W-1:0]  TOTAL_RESET = 17'd65536;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] address;
        logic [CNT_W-1:0]  page_count;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] result_address;
    } rsp_t;

    // Memory access from the sequencer.
    typedef struct packed {
        logic               rd;
        logic               wr;
        logic [WADDR_W-1:0] addr;
        logic [WORD_BITS-1:0] wdata;
    } mem_req_t;

endpackage

// ===== design/bpa_map_ram.sv =====
// Used-page map memory: one write port, one registered read port.
module bpa_map_ram
    import bpa_pkg::*;
(
    input  logic                 clk,
    input  mem_req_t             req,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [MAP_WORDS];

    always_ff @(posedge clk)
    begin
        if (req.wr)
            mem[req.addr] <= req.wdata;
        if (req.rd)
            rdata <= mem[req.addr];
    end

endmodule

// ===== design/bitmap_page_allocator.sv =====
// Top level: bitmap page allocator with first-fit search and clearing pass.
//
//  channel | signals                          | handshake
//  --------+----------------------------------+-----------------------------
//  request | start, busy, req                 | taken when start & !busy
//  result  | done, rsp                        | one-cycle strobe, no stall
//  config  | cfg_valid, cfg_ready, cfg_index, | write when valid & ready
//          | cfg_data                         |
//
//  After reset a clearing pass writes zero to all MAP_WORDS (1024) map words;
//  busy stays high for those cycles. An allocate walks the map one page per
//  cycle, after a word read at each word, from the start hint to the end and
//  then, if needed, again from page 0; marking then costs one read and one
//  write per touched word. Free and reserve take one read/write pair per
//  word of the run. The result strobe cannot be held.
module bitmap_page_allocator
    import bpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  req_t              req,
    output logic              done,
    output rsp_t              rsp,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0] cfg_data
);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_SRD   = 8'b0000_0100,   // search: read word
        S_SCAN  = 8'b0000_1000,   // search: test one page
        S_MRD   = 8'b0001_0000,   // modify: read word
        S_MWR   = 8'b0010_0000,   // modify: write word
        S_DONE  = 8'b0100_0000,
        S_CHK   = 8'b1000_0000    // request checks for alloc, free and reserve
    } state_t;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]  base_reg;
    logic [CNT_W-1:0]   total_reg;
    logic [START_W-1:0] sstart_reg;

    req_t               cur_reg;
    logic [PCNT_W-1:0]  limit_reg;     // managed pages
    logic [PCNT_W-1:0]  pos_reg;       // page under test / to modify
    logic [PCNT_W-1:0]  run_reg;       // free run length
    logic [PCNT_W-1:0]  end_reg;       // end of modify run (exclusive)
    logic               second_reg;    // in wrap pass from page 0
    logic               set_reg;       // modify sets (1) or clears (0)
    logic [WORD_BITS-1:0] word_reg;
    logic               word_loaded_reg; // read data arrives this cycle
    logic [1:0]         status_reg;
    logic [ADDR_W-1:0]  raddr_reg;
    logic [ADDR_W-1:0]  off_reg;       // address - base
    logic               below_reg;
    logic [WADDR_W:0]   clr_reg;

    mem_req_t             mreq;
    logic [WORD_BITS-1:0] rdata;
    logic [WORD_BITS-1:0] word_cur;    // fresh read data or held word

    bpa_map_ram u_ram (.clk(clk), .req(mreq), .rdata(rdata));

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= BASE_RESET;
            total_reg  <= TOTAL_RESET;
            sstart_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BASE:  base_reg   <= cfg_data;
                CFG_TOTAL: total_reg  <= cfg_data[CNT_W-1:0];
                CFG_START: sstart_reg <= cfg_data[START_W-1:0];
                default: ;
            endcase
        end
    end

    logic [PCNT_W-1:0] limit_now;
    logic [PCNT_W-1:0] cnt_w;
    logic [PCNT_W-1:0] pidx;       // page index from offset (clipped view)
    logic              pidx_big;   // offset page index beyond PCNT_W
    logic              page_bit;
    logic [PCNT_W-1:0] pos_inc;
    logic [WORD_BITS-1:0] mask;
    logic [PCNT_W-1:0] word_end;

    assign limit_now = (total_reg > CNT_W'(MAX_PAGES)) ? PCNT_W'(MAX_PAGES)
                                                       : PCNT_W'(total_reg);
    assign cnt_w    = PCNT_W'(cur_reg.page_count);
    assign pidx     = off_reg[PAGE_SHIFT +: PCNT_W];
    assign pidx_big = |(off_reg >> (PAGE_SHIFT + PCNT_W));
    assign word_cur = word_loaded_reg ? rdata : word_reg;
    assign page_bit = word_cur[pos_reg[BIT_W-1:0]];
    assign pos_inc  = pos_reg + 1'b1;
    assign word_end = {pos_reg[PCNT_W-1:BIT_W], BIT_W'(0)} + PCNT_W'(WORD_BITS);

    // Bits of the current word inside [pos, end)
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            logic [PCNT_W-1:0] p;
            p = {pos_reg[PCNT_W-1:BIT_W], BIT_W'(b)};
            mask[b] = (p >= pos_reg) && (p < end_reg);
        end
    end

    always_comb
    begin
        mreq       = '0;
        mreq.addr  = pos_reg[BIT_W +: WADDR_W];
        mreq.wdata = set_reg ? (word_cur | mask) : (word_cur & ~mask);
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                mreq.wr    = 1'b1;
                mreq.addr  = clr_reg[WADDR_W-1:0];
                mreq.wdata = '0;
                if (clr_reg == (WADDR_W+1)'(MAP_WORDS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:   if (start) state_next = S_CHK;
            S_CHK:
            begin
                if (cur_reg.kind == KIND_ALLOC)
                begin
                    if (cnt_w == '0)
                        state_next = S_DONE;
                    else if (cnt_w > limit_reg)
                        state_next = S_DONE;
                    else if (PCNT_W'(sstart_reg) >= limit_reg)
                        state_next = (limit_reg == '0) ? S_DONE : S_SRD;
                    else
                        state_next = S_SRD;
                end
                else if ((cur_reg.kind == KIND_FREE) && !below_reg && !pidx_big
                         && pidx <= limit_reg && cnt_w <= limit_reg - pidx)
                    state_next = (cnt_w == '0) ? S_DONE : S_MRD;
                else if ((cur_reg.kind == KIND_RESERVE) && !below_reg && !pidx_big
                         && pidx < limit_reg && cnt_w != '0)
                    state_next = S_MRD;
                else
                    state_next = S_DONE;
            end
            S_SRD:
            begin
                mreq.rd    = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (!page_bit && run_reg + 1'b1 == cnt_w)
                    state_next = S_MRD;
                else if (pos_inc >= limit_reg)
                    state_next = second_reg ? S_DONE : S_SRD;
                else if (pos_inc[BIT_W-1:0] == '0)
                    state_next = S_SRD;
                else
                    state_next = S_SCAN;
            end
            S_MRD:
            begin
                mreq.rd    = 1'b1;
                state_next = S_MWR;
            end
            S_MWR:
            begin
                mreq.wr    = 1'b1;
                state_next = (word_end >= end_reg) ? S_DONE : S_MRD;
            end
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            word_loaded_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            word_loaded_reg <= (state_reg == S_SRD) || (state_reg == S_MRD);
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + 1'b1;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        word_reg <= word_cur;
        case (state_reg)
            S_IDLE:
            begin
                cur_reg    <= req;
                limit_reg  <= limit_now;
                off_reg    <= req.address - base_reg;
                below_reg  <= req.address < base_reg;
                status_reg <= ST_INVALID;
                raddr_reg  <= '0;
                run_reg    <= '0;
                second_reg <= 1'b0;
            end
            S_CHK:
            begin
                if (cur_reg.kind == KIND_ALLOC)
                begin
                    status_reg <= (cnt_w == '0) ? ST_INVALID : ST_NOMEM;
                    if (PCNT_W'(sstart_reg) >= limit_reg)
                    begin
                        pos_reg    <= '0;
                        second_reg <= 1'b1;
                    end
                    else
                        pos_reg <= PCNT_W'(sstart_reg);
                    set_reg <= 1'b1;
                end
                else
                begin
                    pos_reg <= pidx;
                    set_reg <= (cur_reg.kind == KIND_RESERVE);
                    end_reg <= (cnt_w > limit_reg - pidx) ? limit_reg : pidx + cnt_w;
                    // reserve at or above base is ok even when nothing is marked
                    if (!below_reg &&
                        (((cur_reg.kind == KIND_FREE) && !pidx_big && pidx <= limit_reg
                          && cnt_w <= limit_reg - pidx) ||
                         (cur_reg.kind == KIND_RESERVE)))
                        status_reg <= ST_OK;
                end
            end
            S_SCAN:
            begin
                if (!page_bit && run_reg + 1'b1 == cnt_w)
                begin
                    pos_reg    <= pos_inc - cnt_w;
                    end_reg    <= pos_inc;
                    status_reg <= ST_OK;
                    raddr_reg  <= base_reg + ADDR_W'({pos_inc - cnt_w, PAGE_SHIFT'(0)});
                end
                else if (pos_inc >= limit_reg)
                begin
                    pos_reg    <= '0;
                    run_reg    <= '0;
                    second_reg <= 1'b1;
                end
                else
                begin
                    run_reg <= page_bit ? '0 : run_reg + 1'b1;
                    pos_reg <= pos_inc;
                end
            end
            S_MWR:
                pos_reg <= word_end;
            default: ;
        endcase
    end

    assign done               = (state_reg == S_DONE);
    assign rsp.status         = status_reg;
    assign rsp.result_address = raddr_reg;

    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request not taken");
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");
    a_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != ST_OK) |-> rsp.result_address == '0)
        else $error("address on failed request");

endmodule
